[rtl/ecsm_pkg.sv]
// shared types and constants for the elliptic-curve scalar multiplier
package ecsm_pkg;

  localparam int unsigned FIELD_BITS_DEF = 64;
  localparam int unsigned SCALAR_BITS    = 64;
  localparam int unsigned REG_BITS       = 64;
  localparam int unsigned BIT_IDX_BITS   = $clog2(SCALAR_BITS);

  typedef enum logic [0:0] {
    REG_MODULUS = 1'b0,
    REG_CURVE_A = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef struct packed {
    logic    req;
    alu_op_e op;
  } alu_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_X,
    ST_RED_Y,
    ST_DBL_CHK,
    ST_DBL_DEN,
    ST_ADD_CHK,
    ST_ADD_DEN,
    ST_INV_TEST,
    ST_INV_DIV,
    ST_INV_QRED,
    ST_INV_MUL,
    ST_INV_SUB,
    ST_DBL_SQ,
    ST_DBL_N2,
    ST_DBL_N3,
    ST_DBL_N4,
    ST_ADD_NUM,
    ST_LAM,
    ST_FIN_SQ,
    ST_FIN_S1,
    ST_FIN_S2,
    ST_FIN_D,
    ST_FIN_M,
    ST_FIN_Y,
    ST_POST,
    ST_NEXT,
    ST_OUT
  } state_e;

endpackage

[rtl/ecsm_arith.sv]
// shared modular arithmetic unit: add, sub, bit-serial multiply, restoring divide
module ecsm_arith import ecsm_pkg::*; #(
  parameter int unsigned W = FIELD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  alu_cmd_t     cmd_i,
  input  logic [W-1:0] opa_i,
  input  logic [W-1:0] opb_i,
  input  logic [W-1:0] mod_i,
  output logic         done_o,
  output logic [W-1:0] res_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          run_q, done_q;
  alu_op_e       op_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  acc_q, sh_q, ua_q, m_q;
  logic [W-1:0]  dbl, mul_nx;
  logic [W:0]    dtry;
  logic          dfit;

  function automatic logic [W-1:0] fadd(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fsub(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] m);
    return (x >= y) ? (x - y) : (x - y + m);
  endfunction

  always_comb begin
    dbl    = fadd(acc_q, acc_q, m_q);
    mul_nx = sh_q[W-1] ? fadd(dbl, ua_q, m_q) : dbl;
    dtry   = {acc_q, sh_q[W-1]};
    dfit   = (dtry >= {1'b0, ua_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (cmd_i.req && !done_q) begin
        case (cmd_i.op)
          OP_ADD, OP_SUB: done_q <= 1'b1;
          default:        run_q  <= 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      case (op_q)
        OP_MUL: begin
          acc_q <= mul_nx;
          sh_q  <= {sh_q[W-2:0], 1'b0};
        end
        default: begin
          acc_q <= dfit ? W'(dtry - {1'b0, ua_q}) : dtry[W-1:0];
          sh_q  <= {sh_q[W-2:0], dfit};
        end
      endcase
    end else if (cmd_i.req && !done_q) begin
      op_q  <= cmd_i.op;
      m_q   <= mod_i;
      cnt_q <= CW'(W - 1);
      case (cmd_i.op)
        OP_ADD: acc_q <= fadd(opa_i, opb_i, mod_i);
        OP_SUB: acc_q <= fsub(opa_i, opb_i, mod_i);
        OP_MUL: begin
          acc_q <= '0;
          ua_q  <= opa_i;
          sh_q  <= opb_i;
        end
        default: begin
          acc_q <= '0;
          sh_q  <= opa_i;
          ua_q  <= opb_i;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_DIV) ? sh_q : acc_q;
  assign rem_o  = acc_q;

endmodule

[rtl/ec_point_scalar_multiply.sv]
// top level: scalar times affine point by double-and-add over one shared arithmetic unit
//
// usage: drive point_x_i, point_y_i and scalar_i and raise start; the beat is
// taken at a clock edge with start high and busy low. busy stays high until the
// result beat, which appears for exactly one cycle with done_o high, carrying
// result_x_o, result_y_o and at_infinity_o (coordinates zero at infinity).
// configuration (modulus, curve_a) is written through cfg_we_i / cfg_idx_i /
// cfg_data_i while busy is low; reset loads modulus 17 and curve_a 2.
// steps: an infinity-only result goes straight to the output; otherwise three
// reductions, then for each of the 64 scalar bits a doubling and, on a set bit,
// an addition. each group operation costs one inversion by extended euclid (up to
// roughly 1.5*FIELD_BITS quotient steps) plus up to four multiplies on the
// bit-serial multiply/divide unit.
// one beat at a time: the next start is taken the cycle the result appears.
// the receiver cannot stall; reset returns the block to idle at once.
module ec_point_scalar_multiply import ecsm_pkg::*; #(
  parameter int unsigned FIELD_BITS = FIELD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [REG_BITS-1:0] point_x_i,
  input  logic [REG_BITS-1:0] point_y_i,
  input  logic [SCALAR_BITS-1:0] scalar_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [REG_BITS-1:0] cfg_data_i,
  output logic                done_o,
  output logic [REG_BITS-1:0] result_x_o,
  output logic [REG_BITS-1:0] result_y_o,
  output logic                at_infinity_o
);

  localparam int unsigned W = FIELD_BITS;

  state_e state_q, state_d;
  logic [REG_BITS-1:0] modulus_q, curve_a_q;
  logic [W-1:0] m_q, a_q, bx_q, by_q, ax_q, ay_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q, q_q, rm_q, num_q, tmp_q, lam_q, xr_q;
  logic [SCALAR_BITS-1:0] k_q;
  logic [BIT_IDX_BITS-1:0] bit_q;
  logic ainf_q, ph_q, sel_dbl_q, done_q;
  logic [REG_BITS-1:0] rx_q, ry_q;
  logic rinf_q;

  alu_cmd_t cmd;
  logic [W-1:0] opa, opb, alu_res, alu_rem;
  logic alu_done, trivial, accept;
  logic [W-1:0] mw, xw, yw;

  assign mw      = modulus_q[W-1:0];
  assign xw      = point_x_i[W-1:0];
  assign yw      = point_y_i[W-1:0];
  assign trivial = (mw < W'(2)) || (xw == '0 && yw == '0) || (scalar_i == '0);
  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);

  ecsm_arith #(.W(W)) u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .opa_i (opa),
    .opb_i (opb),
    .mod_i (m_q),
    .done_o(alu_done),
    .res_o (alu_res),
    .rem_o (alu_rem)
  );

  // operand selection per step
  always_comb begin
    cmd.req = 1'b1;
    cmd.op  = OP_ADD;
    opa     = '0;
    opb     = '0;
    unique case (state_q)
      ST_RED_A:    begin cmd.op = OP_DIV; opa = a_q;   opb = m_q;  end
      ST_RED_X:    begin cmd.op = OP_DIV; opa = bx_q;  opb = m_q;  end
      ST_RED_Y:    begin cmd.op = OP_DIV; opa = by_q;  opb = m_q;  end
      ST_DBL_DEN:  begin cmd.op = OP_ADD; opa = ay_q;  opb = ay_q; end
      ST_ADD_DEN:  begin cmd.op = OP_SUB; opa = bx_q;  opb = ax_q; end
      ST_INV_DIV:  begin cmd.op = OP_DIV; opa = r0_q;  opb = r1_q; end
      ST_INV_QRED: begin cmd.op = OP_ADD; opa = q_q;   opb = '0;   end
      ST_INV_MUL:  begin cmd.op = OP_MUL; opa = q_q;   opb = t1_q; end
      ST_INV_SUB:  begin cmd.op = OP_SUB; opa = t0_q;  opb = q_q;  end
      ST_DBL_SQ:   begin cmd.op = OP_MUL; opa = ax_q;  opb = ax_q; end
      ST_DBL_N2:   begin cmd.op = OP_ADD; opa = num_q; opb = num_q; end
      ST_DBL_N3:   begin cmd.op = OP_ADD; opa = tmp_q; opb = num_q; end
      ST_DBL_N4:   begin cmd.op = OP_ADD; opa = num_q; opb = a_q;  end
      ST_ADD_NUM:  begin cmd.op = OP_SUB; opa = by_q;  opb = ay_q; end
      ST_LAM:      begin cmd.op = OP_MUL; opa = num_q; opb = t0_q; end
      ST_FIN_SQ:   begin cmd.op = OP_MUL; opa = lam_q; opb = lam_q; end
      ST_FIN_S1:   begin cmd.op = OP_SUB; opa = tmp_q; opb = ax_q; end
      ST_FIN_S2:   begin cmd.op = OP_SUB; opa = tmp_q; opb = sel_dbl_q ? ax_q : bx_q; end
      ST_FIN_D:    begin cmd.op = OP_SUB; opa = ax_q;  opb = xr_q; end
      ST_FIN_M:    begin cmd.op = OP_MUL; opa = lam_q; opb = tmp_q; end
      ST_FIN_Y:    begin cmd.op = OP_SUB; opa = tmp_q; opb = ay_q; end
      default:     cmd.req = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start) state_d = trivial ? ST_OUT : ST_RED_A;
      ST_RED_A:    if (alu_done) state_d = ST_RED_X;
      ST_RED_X:    if (alu_done) state_d = ST_RED_Y;
      ST_RED_Y:    if (alu_done) state_d = ST_DBL_CHK;
      ST_DBL_CHK:  state_d = ainf_q ? ST_POST : ST_DBL_DEN;
      ST_ADD_CHK: begin
        if (ainf_q) state_d = ST_POST;
        else if (ax_q == bx_q && ay_q == by_q) state_d = ST_DBL_DEN;
        else state_d = ST_ADD_DEN;
      end
      ST_DBL_DEN:  if (alu_done) state_d = ST_INV_TEST;
      ST_ADD_DEN:  if (alu_done) state_d = ST_INV_TEST;
      ST_INV_TEST: begin
        if (r1_q != '0) state_d = ST_INV_DIV;
        else if (r0_q == W'(1)) state_d = sel_dbl_q ? ST_DBL_SQ : ST_ADD_NUM;
        else state_d = ST_POST;
      end
      ST_INV_DIV:  if (alu_done) state_d = ST_INV_QRED;
      ST_INV_QRED: if (alu_done) state_d = ST_INV_MUL;
      ST_INV_MUL:  if (alu_done) state_d = ST_INV_SUB;
      ST_INV_SUB:  if (alu_done) state_d = ST_INV_TEST;
      ST_DBL_SQ:   if (alu_done) state_d = ST_DBL_N2;
      ST_DBL_N2:   if (alu_done) state_d = ST_DBL_N3;
      ST_DBL_N3:   if (alu_done) state_d = ST_DBL_N4;
      ST_DBL_N4:   if (alu_done) state_d = ST_LAM;
      ST_ADD_NUM:  if (alu_done) state_d = ST_LAM;
      ST_LAM:      if (alu_done) state_d = ST_FIN_SQ;
      ST_FIN_SQ:   if (alu_done) state_d = ST_FIN_S1;
      ST_FIN_S1:   if (alu_done) state_d = ST_FIN_S2;
      ST_FIN_S2:   if (alu_done) state_d = ST_FIN_D;
      ST_FIN_D:    if (alu_done) state_d = ST_FIN_M;
      ST_FIN_M:    if (alu_done) state_d = ST_FIN_Y;
      ST_FIN_Y:    if (alu_done) state_d = ST_POST;
      ST_POST:     state_d = (!ph_q && k_q[bit_q]) ? ST_ADD_CHK : ST_NEXT;
      ST_NEXT:     state_d = (bit_q == '0) ? ST_OUT : ST_DBL_CHK;
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      modulus_q <= REG_BITS'(17);
      curve_a_q <= REG_BITS'(2);
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_OUT);
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MODULUS: modulus_q <= cfg_data_i;
          REG_CURVE_A: curve_a_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (start) begin
        m_q    <= mw;
        a_q    <= curve_a_q[W-1:0];
        bx_q   <= xw;
        by_q   <= yw;
        k_q    <= scalar_i;
        bit_q  <= BIT_IDX_BITS'(SCALAR_BITS - 1);
        ainf_q <= 1'b1;
      end
      ST_RED_A: if (alu_done) a_q  <= alu_rem;
      ST_RED_X: if (alu_done) bx_q <= alu_rem;
      ST_RED_Y: if (alu_done) by_q <= alu_rem;
      ST_DBL_CHK: begin
        ph_q      <= 1'b0;
        sel_dbl_q <= 1'b1;
      end
      ST_ADD_CHK: begin
        ph_q      <= 1'b1;
        sel_dbl_q <= (ax_q == bx_q && ay_q == by_q);
        if (ainf_q) begin
          ax_q   <= bx_q;
          ay_q   <= by_q;
          ainf_q <= 1'b0;
        end
      end
      ST_DBL_DEN, ST_ADD_DEN: if (alu_done) begin
        r1_q <= alu_res;
        r0_q <= m_q;
        t0_q <= '0;
        t1_q <= W'(1);
      end
      ST_INV_TEST: if (r1_q == '0 && r0_q != W'(1)) ainf_q <= 1'b1;
      ST_INV_DIV: if (alu_done) begin
        q_q  <= alu_res;
        rm_q <= alu_rem;
      end
      ST_INV_QRED, ST_INV_MUL: if (alu_done) q_q <= alu_res;
      ST_INV_SUB: if (alu_done) begin
        t1_q <= alu_res;
        t0_q <= t1_q;
        r0_q <= r1_q;
        r1_q <= rm_q;
      end
      ST_DBL_SQ, ST_DBL_N3, ST_DBL_N4, ST_ADD_NUM: if (alu_done) num_q <= alu_res;
      ST_DBL_N2, ST_FIN_SQ, ST_FIN_S1, ST_FIN_D, ST_FIN_M: if (alu_done) tmp_q <= alu_res;
      ST_LAM:    if (alu_done) lam_q <= alu_res;
      ST_FIN_S2: if (alu_done) xr_q <= alu_res;
      ST_FIN_Y: if (alu_done) begin
        ay_q   <= alu_res;
        ax_q   <= xr_q;
        ainf_q <= 1'b0;
      end
      ST_NEXT: if (bit_q != '0) bit_q <= bit_q - 1'b1;
      ST_OUT: begin
        rinf_q <= ainf_q;
        rx_q   <= ainf_q ? '0 : REG_BITS'(ax_q);
        ry_q   <= ainf_q ? '0 : REG_BITS'(ay_q);
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign result_x_o    = rx_q;
  assign result_y_o    = ry_q;
  assign at_infinity_o = rinf_q;

  a_fell_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped without a result beat");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted beat did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");

  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && at_infinity_o |-> result_x_o == '0 && result_y_o == '0)
    else $error("infinity result with nonzero coordinates");

  a_idle_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !cmd.req) else $error("arithmetic unit requested while idle");

endmodule
